@@ design/bbcd_pkg.sv @@
// Package for the block buffer cache directory.
// Holds sizes, operation and status codes, payload structs and the controller state and command types.
// No dependencies.
package bbcd_pkg;

  localparam int NUM_SLOTS       = 32;
  localparam int NUM_DISK_BLOCKS = 8192;
  localparam int AGE_BITS        = 16;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int LANES     = 1 << SLOT_W;
  localparam int LEVELS    = SLOT_W;
  localparam int LVL_CNT_W = $clog2(LEVELS + 1);
  localparam int TAG_W     = $clog2(NUM_DISK_BLOCKS);
  localparam int BN_W      = 16;
  localparam int KEY_W     = AGE_BITS + 1;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_DIRTY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOB  = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [BN_W-1:0]  block_number;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot_index;
    logic        writeback_valid;
    logic [12:0] writeback_block;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic reduce;
    logic commit;
  } cmd_t;

endpackage

@@ design/bbcd_ctrl.sv @@
// Controller of the block buffer cache directory.
// Sequences capture, lane load, tree reduction and commit; drives the handshakes.
// Depends on bbcd_pkg.
module bbcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bbcd_pkg::cmd_t cmd
);
  import bbcd_pkg::*;

  localparam logic [LVL_CNT_W-1:0] LVL_LAST = LVL_CNT_W'(LEVELS - 1);

  state_t                state;
  state_t                state_next;
  logic [LVL_CNT_W-1:0]  lvl_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      lvl_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_REDUCE) begin
        lvl_cnt <= lvl_cnt + 1'b1;
      end else begin
        lvl_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (lvl_cnt == LVL_LAST) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_LOAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.reduce, cmd.commit}))
    else $error("more than one datapath step at once");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

  a_reduce_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE && lvl_cnt == LVL_LAST) |=> cmd.commit)
    else $error("reduction did not end in commit");
`endif

endmodule

@@ design/bbcd_dp.sv @@
// Datapath of the block buffer cache directory.
// Holds slot state, the candidate reduction lanes and the result register.
// Depends on bbcd_pkg.
module bbcd_dp (
  input  logic           clk,
  input  logic           rst,
  input  bbcd_pkg::cmd_t  cmd,
  input  bbcd_pkg::in_t   in_data,
  output bbcd_pkg::out_t  out_data
);
  import bbcd_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  in_t                  req;
  logic                 req_oob;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_dirty;
  logic [TAG_W-1:0]     slot_tag [NUM_SLOTS];
  logic [AGE_BITS-1:0]  slot_age [NUM_SLOTS];
  logic [AGE_BITS-1:0]  age_inc  [NUM_SLOTS];

  logic [KEY_W-1:0]     cand_key   [LANES];
  logic [SLOT_W-1:0]    cand_idx   [LANES];
  logic                 cand_dirty [LANES];
  logic [TAG_W-1:0]     cand_tag   [LANES];

  logic [TAG_W-1:0]     req_tag;
  logic                 is_alloc;
  logic                 is_mark;
  logic                 win_hit;
  logic [SLOT_W-1:0]    win_idx;
  logic                 evict_dirty;
  out_t                 res;
  out_t                 res_next;

  assign req_tag  = req.block_number[TAG_W-1:0];
  assign is_alloc = (req.func == FUNC_ALLOC);
  assign is_mark  = (req.func == FUNC_DIRTY);
  assign win_idx  = cand_idx[0];
  assign win_hit  = cand_key[0][AGE_BITS];
  assign evict_dirty = !win_hit && cand_dirty[0];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      age_inc[i] = (slot_age[i] == AGE_MAX) ? slot_age[i] : slot_age[i] + 1'b1;
    end
  end

  always_comb begin
    res_next = '0;
    if (req_oob) begin
      res_next.status = STATUS_OOB;
    end else begin
      unique case (req.func)
        FUNC_ALLOC: begin
          res_next.status          = STATUS_OK;
          res_next.slot_index      = 5'(win_idx);
          res_next.writeback_valid = evict_dirty;
          res_next.writeback_block = evict_dirty ? 13'(cand_tag[0]) : 13'd0;
        end
        default: begin
          if (win_hit) begin
            res_next.status     = STATUS_OK;
            res_next.slot_index = 5'(win_idx);
          end else begin
            res_next.status = STATUS_MISS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req     <= in_data;
      req_oob <= {1'b0, in_data.block_number} >= (BN_W + 1)'(NUM_DISK_BLOCKS);
    end
    if (cmd.commit) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < LANES; i++) begin
        cand_idx[i] <= SLOT_W'(i);
        if (i < NUM_SLOTS) begin
          cand_dirty[i] <= slot_dirty[i];
          cand_tag[i]   <= slot_tag[i];
          if (is_alloc) begin
            cand_key[i] <= slot_valid[i] ? {1'b0, age_inc[i]} : {1'b1, {AGE_BITS{1'b0}}};
          end else begin
            cand_key[i] <= {slot_valid[i] && (slot_tag[i] == req_tag), {AGE_BITS{1'b0}}};
          end
        end else begin
          cand_dirty[i] <= 1'b0;
          cand_tag[i]   <= '0;
          cand_key[i]   <= '0;
        end
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < LANES / 2; i++) begin
        if (cand_key[2*i+1] > cand_key[2*i]) begin
          cand_key[i]   <= cand_key[2*i+1];
          cand_idx[i]   <= cand_idx[2*i+1];
          cand_dirty[i] <= cand_dirty[2*i+1];
          cand_tag[i]   <= cand_tag[2*i+1];
        end else begin
          cand_key[i]   <= cand_key[2*i];
          cand_idx[i]   <= cand_idx[2*i];
          cand_dirty[i] <= cand_dirty[2*i];
          cand_tag[i]   <= cand_tag[2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !req_oob && is_alloc) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (win_idx == SLOT_W'(i)) begin
          slot_tag[i] <= req_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_age[i] <= '0;
      end
    end else begin
      if (cmd.load && !req_oob && is_alloc) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot_age[i] <= age_inc[i];
        end
      end
      if (cmd.commit && !req_oob) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (win_idx == SLOT_W'(i)) begin
            if (is_alloc) begin
              slot_valid[i] <= 1'b1;
              slot_dirty[i] <= 1'b0;
              slot_age[i]   <= '0;
            end else if (is_mark && win_hit) begin
              slot_dirty[i] <= 1'b1;
            end
          end
        end
      end
    end
  end

  assign out_data = res;

`ifndef ASSERT_OFF
  a_alloc_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !req_oob && is_alloc) |=> slot_valid[$past(win_idx)])
    else $error("allocated slot not valid");

  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> (!res.writeback_valid || res.status == STATUS_OK))
    else $error("write-back reported on a failed request");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> (res.status == STATUS_OK || res.slot_index == 5'd0))
    else $error("slot index set on a failed request");
`endif

endmodule

@@ design/block_buffer_cache_directory_top.sv @@
// Directory of a fully associative block buffer with oldest-first replacement. Each request
// word passes through capture, then aging of the slots (allocations only) and loading of the
// candidate lanes, then one step per level of the registered max/first-match tree, and a
// commit of the slot update. A new word is taken in the cycle its predecessor's result is
// taken, so the block holds only one request at a time.
// Depends on bbcd_pkg, bbcd_ctrl and bbcd_dp.
module block_buffer_cache_directory_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbcd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bbcd_pkg::out_t out_data
);
  import bbcd_pkg::*;

  cmd_t cmd;

  bbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbcd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for block_buffer_cache_directory_top: directed and random request words,
// a predictor of the slot directory, and result checking. Depends on bbcd_pkg.
module tb_top;
  import bbcd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 1750;
  localparam int POOL_SIZE     = 64;
  localparam int RECENT_DEPTH  = 40;
  localparam int DRAIN_CYCLES  = 24;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_words[$];
  out_t expected_replies[$];
  logic [BN_W-1:0] recent_blocks[$];
  logic [BN_W-1:0] block_pool[POOL_SIZE];

  logic                slot_valid[NUM_SLOTS];
  logic                slot_dirty[NUM_SLOTS];
  logic [TAG_W-1:0]    slot_tag[NUM_SLOTS];
  logic [AGE_BITS-1:0] slot_age[NUM_SLOTS];

  int  words_total = 0;
  int  words_accepted = 0;
  int  replies_checked = 0;
  int  writebacks_seen = 0;
  int  evictions_seen = 0;
  int  misses_seen = 0;
  int  err_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;

  block_buffer_cache_directory_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic out_t predict_directory(in_t w);
    out_t r;
    int   s;
    int   i;
    r = '0;
    s = -1;
    if (w.block_number >= NUM_DISK_BLOCKS) begin
      r.status = STATUS_OOB;
    end else if (w.func == FUNC_ALLOC) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (slot_age[i] != AGE_MAX) slot_age[i] = slot_age[i] + 1'b1;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_valid[i] && s < 0) s = i;
      end
      if (s < 0) begin
        s = 0;
        for (i = 1; i < NUM_SLOTS; i++) begin
          if (slot_age[i] > slot_age[s]) s = i;
        end
        evictions_seen++;
        if (slot_dirty[s]) begin
          r.writeback_valid = 1'b1;
          r.writeback_block = 13'(slot_tag[s]);
          writebacks_seen++;
        end
      end
      slot_valid[s] = 1'b1;
      slot_dirty[s] = 1'b0;
      slot_age[s]   = '0;
      slot_tag[s]   = w.block_number[TAG_W-1:0];
      r.slot_index  = 5'(s);
    end else begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (s < 0 && slot_valid[i] && slot_tag[i] == w.block_number[TAG_W-1:0]) s = i;
      end
      if (s < 0) begin
        r.status = STATUS_MISS;
        misses_seen++;
      end else begin
        if (w.func == FUNC_DIRTY) slot_dirty[s] = 1'b1;
        r.slot_index = 5'(s);
      end
    end
    return r;
  endfunction

  function automatic int idle_pct(bit sender_side);
    if (words_accepted * 3 < words_total) return sender_side ? 24 : 71;
    if (words_accepted * 3 < words_total * 2) return sender_side ? 71 : 24;
    return 0;
  endfunction

  task automatic queue_word(logic [1:0] f, logic [BN_W-1:0] bn);
    in_t w;
    w.func         = func_t'(f);
    w.block_number = bn;
    pending_words.push_back(w);
    if (f == FUNC_ALLOC && bn < NUM_DISK_BLOCKS) begin
      recent_blocks.push_back(bn);
      if (recent_blocks.size() > RECENT_DEPTH) void'(recent_blocks.pop_front());
    end
  endtask

  task automatic queue_random_word();
    int              pick;
    logic [1:0]      f;
    logic [BN_W-1:0] bn;
    pick = $urandom_range(99);
    if (pick < 40)      f = FUNC_ALLOC;
    else if (pick < 72) f = FUNC_LOOKUP;
    else if (pick < 92) f = FUNC_DIRTY;
    else                f = FUNC_UNKNOWN;
    pick = $urandom_range(99);
    if (pick < 6)
      bn = BN_W'($urandom_range(65535, NUM_DISK_BLOCKS));
    else if (pick < 56 && recent_blocks.size() != 0)
      bn = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
    else if (pick < 90)
      bn = block_pool[$urandom_range(POOL_SIZE - 1)];
    else
      bn = BN_W'($urandom_range(NUM_DISK_BLOCKS - 1));
    queue_word(f, bn);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    out_t want;
    in_taken = in_valid && in_ready && !rst;
    if (in_taken) begin
      expected_replies.push_back(predict_directory(in_data));
      words_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d", out_data.status,
               out_data.slot_index);
        err_count++;
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_count++;
        end
        if (out_data.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_data.slot_index);
          err_count++;
        end
        if (out_data.writeback_valid !== want.writeback_valid) begin
          $error("writeback_valid: expected %0d, got %0d", want.writeback_valid,
                 out_data.writeback_valid);
          err_count++;
        end
        if (out_data.writeback_block !== want.writeback_block) begin
          $error("writeback_block: expected %0d, got %0d", want.writeback_block,
                 out_data.writeback_block);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timed out with %0d results outstanding", expected_replies.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_tag[i]   = '0;
      slot_age[i]   = '0;
    end
    for (i = 0; i < POOL_SIZE; i++) block_pool[i] = BN_W'($urandom_range(NUM_DISK_BLOCKS - 1));

    // misses on an empty directory, out-of-range numbers, hits, duplicates
    queue_word(FUNC_LOOKUP, 16'd0);
    queue_word(FUNC_DIRTY, 16'(NUM_DISK_BLOCKS - 1));
    queue_word(FUNC_UNKNOWN, 16'd5);
    queue_word(FUNC_ALLOC, 16'(NUM_DISK_BLOCKS));
    queue_word(FUNC_LOOKUP, 16'hFFFF);
    queue_word(FUNC_DIRTY, 16'hFFFF);
    queue_word(FUNC_UNKNOWN, 16'hE000);
    queue_word(FUNC_ALLOC, 16'd0);
    queue_word(FUNC_ALLOC, 16'(NUM_DISK_BLOCKS - 1));
    queue_word(FUNC_ALLOC, 16'(NUM_DISK_BLOCKS - 1));
    queue_word(FUNC_LOOKUP, 16'(NUM_DISK_BLOCKS - 1));
    queue_word(FUNC_DIRTY, 16'(NUM_DISK_BLOCKS - 1));
    queue_word(FUNC_DIRTY, 16'd0);
    queue_word(FUNC_UNKNOWN, 16'd0);
    queue_word(FUNC_LOOKUP, 16'h1555);
    queue_word(FUNC_ALLOC, 16'h0AAA);
    queue_word(FUNC_LOOKUP, 16'h0AAA);
    queue_word(FUNC_ALLOC, 16'h8000);
    for (i = 0; i < RANDOM_WORDS; i++) queue_random_word();
    words_total = pending_words.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d request words, %0d results checked, %0d directory misses",
             words_accepted, replies_checked, misses_seen);
    $display("tb_top: %0d evictions, %0d of them with dirty write-back",
             evictions_seen, writebacks_seen);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
